>>> design/sapa_pkg.sv
// shared types, codes and defaults for the subnet address pool allocator
package sapa_pkg;

  localparam int WORD_BITS          = 32;
  localparam int DEF_POOL_ADDR_BITS = 10;

  // request command codes
  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_RESERVE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  // configuration register select (paddr bit 2)
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_PREFIX = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic req_load;
    logic sweep_write;
    logic sweep_mark;
    logic scan_init;
    logic scan_step;
    logic rmw_read;
    logic rmw_exec;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic scan_done;
  } dp_status_t;

endpackage

>>> design/sapa_ram.sv
// generic single write port, single read port ram with registered read data
module sapa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sapa_ctrl.sv
// control state machine of the subnet address pool allocator
module sapa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           in_cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sapa_pkg::ctrl_cmd_t  cmd_o,
  input  sapa_pkg::dp_status_t status_i
);
  import sapa_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CLEAR  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_RD     = 7'b0010000,
    S_EXEC   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        // clearing pass after reset, no result
        cmd_o.sweep_write = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          unique case (cmd_e'(in_cmd_i))
            CMD_CLEAR: begin
              state_d = S_CLEAR;
            end
            CMD_ALLOC: begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
            CMD_RELEASE, CMD_RESERVE, CMD_QUERY: begin
              state_d = S_RD;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_write = 1'b1;
        cmd_o.sweep_mark  = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_RD: begin
        cmd_o.rmw_read = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.rmw_exec = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/sapa_dp.sv
// datapath: config registers, used bitmap, scan, read-modify-write and result registers
module sapa_dp #(
  parameter int POOL_ADDR_BITS = sapa_pkg::DEF_POOL_ADDR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sapa_pkg::ctrl_cmd_t  cmd_i,
  output sapa_pkg::dp_status_t status_o,
  input  logic [2:0]           in_cmd_i,
  input  logic [31:0]          in_host_address_i,
  output logic [31:0]          out_result_address_o,
  output logic [1:0]           out_status_o,
  output logic                 out_is_free_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata
);
  import sapa_pkg::*;

  localparam int POOL_WORDS = (POOL_ADDR_BITS > 5) ? 2 ** (POOL_ADDR_BITS - 5) : 1;
  localparam int WORD_AW    = (POOL_ADDR_BITS > 5) ? POOL_ADDR_BITS - 5 : 1;
  localparam int HB         = $clog2(POOL_ADDR_BITS + 1);
  localparam logic [5:0]         PFX_LO    = 6'(32 - POOL_ADDR_BITS);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(POOL_WORDS - 1);

  function automatic logic [4:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  // configuration registers
  logic [31:0] base_q;
  logic [5:0]  prefix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      prefix_q <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BASE:   base_q   <= pwdata;
        REG_PREFIX: prefix_q <= pwdata[5:0];
        default:    base_q   <= base_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE:   prdata = base_q;
      REG_PREFIX: prdata = {26'b0, prefix_q};
      default:    prdata = '0;
    endcase
  end

  // subnet geometry
  logic [5:0]         pfx_eff;
  logic [HB-1:0]      host_bits;
  logic [31:0]        net_mask, host_mask, net_base;
  logic               has_reserved, small_net;
  logic [4:0]         hosts_small;
  logic [31:0]        scan_valid;
  logic [WORD_AW-1:0] last_word;

  always_comb begin
    if (prefix_q < PFX_LO) begin
      pfx_eff = PFX_LO;
    end else if (prefix_q > 6'd32) begin
      pfx_eff = 6'd32;
    end else begin
      pfx_eff = prefix_q;
    end
  end

  assign host_bits    = HB'(6'd32 - pfx_eff);
  assign net_mask     = 32'hFFFF_FFFF << host_bits;
  assign host_mask    = ~net_mask;
  assign net_base     = base_q & net_mask;
  assign has_reserved = 6'(host_bits) >= 6'd2;
  assign small_net    = 6'(host_bits) < 6'd5;
  assign hosts_small  = 5'd1 << host_bits;
  assign scan_valid   = small_net ? ~(32'hFFFF_FFFF << hosts_small) : 32'hFFFF_FFFF;
  assign last_word    = host_mask[5 +: WORD_AW];

  // request registers
  logic [2:0]  req_cmd_q;
  logic [31:0] req_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_cmd_q  <= in_cmd_i;
      req_addr_q <= in_host_address_i;
    end
  end

  logic               in_subnet;
  logic [31:0]        tgt_off;
  logic [WORD_AW-1:0] tgt_word;
  logic [31:0]        tgt_mask;

  assign in_subnet = (req_addr_q & net_mask) == net_base;
  assign tgt_off   = req_addr_q & host_mask;
  assign tgt_word  = tgt_off[5 +: WORD_AW];
  assign tgt_mask  = 32'd1 << tgt_off[4:0];

  // clear sweep pointer, wraps back to zero after the last word
  logic [WORD_AW-1:0] sweep_ptr_q;
  logic               sweep_last;
  logic [31:0]        sweep_word;

  assign sweep_last = sweep_ptr_q == LAST_WORD;

  always_comb begin
    sweep_word = '0;
    if (cmd_i.sweep_mark && has_reserved) begin
      if (sweep_ptr_q == '0) begin
        sweep_word[0] = 1'b1;
      end
      if (sweep_ptr_q == last_word) begin
        sweep_word = sweep_word | (32'd1 << host_mask[4:0]);
      end
    end
  end

  // allocate scan: one word read per cycle, checked in the following cycle
  logic [WORD_AW:0]   issue_ptr_q;
  logic [WORD_AW-1:0] chk_ptr_q;
  logic               pend_q;
  logic               issue_ok;
  logic [31:0]        rd_data;
  logic [31:0]        free_bits;
  logic [4:0]         free_idx;
  logic               found, exhausted;

  assign issue_ok  = issue_ptr_q <= {1'b0, last_word};
  assign free_bits = ~rd_data & scan_valid;
  assign free_idx  = first_set(free_bits);
  assign found     = pend_q & (|free_bits);
  assign exhausted = pend_q & ~(|free_bits) & (chk_ptr_q == last_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_ptr_q <= '0;
      issue_ptr_q <= '0;
      chk_ptr_q   <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (cmd_i.sweep_write) begin
        sweep_ptr_q <= sweep_last ? '0 : sweep_ptr_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        issue_ptr_q <= '0;
        pend_q      <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_q <= issue_ok;
        if (issue_ok) begin
          issue_ptr_q <= issue_ptr_q + 1'b1;
          chk_ptr_q   <= issue_ptr_q[WORD_AW-1:0];
        end
      end
    end
  end

  assign status_o.sweep_last = sweep_last;
  assign status_o.scan_done  = found | exhausted;

  // memory port muxing
  logic               ram_we, ram_re;
  logic [WORD_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_ptr_q;
    ram_wdata = sweep_word;
    if (cmd_i.sweep_write) begin
      ram_we = 1'b1;
    end else if (cmd_i.scan_step && found) begin
      ram_we    = 1'b1;
      ram_waddr = chk_ptr_q;
      ram_wdata = rd_data | (32'd1 << free_idx);
    end else if (cmd_i.rmw_exec && in_subnet) begin
      ram_waddr = tgt_word;
      unique case (cmd_e'(req_cmd_q))
        CMD_RELEASE: begin
          ram_we    = 1'b1;
          ram_wdata = rd_data & ~tgt_mask;
        end
        CMD_RESERVE: begin
          ram_we    = 1'b1;
          ram_wdata = rd_data | tgt_mask;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  assign ram_re    = cmd_i.rmw_read | (cmd_i.scan_step & issue_ok);
  assign ram_raddr = cmd_i.rmw_read ? tgt_word : issue_ptr_q[WORD_AW-1:0];

  sapa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (POOL_WORDS),
    .AW    (WORD_AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // pending result and output registers
  logic [31:0] res_addr_q, out_addr_q;
  status_e     res_status_q, out_status_q;
  logic        res_free_q, out_free_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      res_addr_q   <= '0;
      res_status_q <= cmd_i.scan_init ? ST_NO_FREE : ST_OK;
      res_free_q   <= 1'b0;
    end else if (cmd_i.scan_step && found) begin
      res_addr_q   <= net_base | 32'({chk_ptr_q, free_idx});
      res_status_q <= ST_OK;
    end else if (cmd_i.rmw_exec) begin
      if (cmd_e'(req_cmd_q) == CMD_RESERVE && !in_subnet) begin
        res_status_q <= ST_OUTSIDE;
      end
      if (cmd_e'(req_cmd_q) == CMD_QUERY) begin
        res_free_q <= in_subnet & ~rd_data[tgt_off[4:0]];
      end
    end
    if (cmd_i.out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_free_q   <= res_free_q;
    end
  end

  assign out_result_address_o = out_addr_q;
  assign out_status_o         = out_status_q;
  assign out_is_free_o        = out_free_q;

endmodule

>>> design/subnet_address_pool_allocator_top.sv
// top level of the subnet address pool allocator
// operation: clear sweeps all bitmap words, release, reserve and query read one word,
//   release and reserve write it back, allocate scans one bitmap word per cycle
// throughput: one request at a time, in_stall_o stays high until the controller is idle
// reset: async active low; a clearing pass over all POOL_WORDS words (32 by default)
//   zeroes the bitmap while in_stall_o stays high, config resets to base 0, prefix 32
module subnet_address_pool_allocator_top #(
  parameter int POOL_ADDR_BITS = sapa_pkg::DEF_POOL_ADDR_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_cmd_i,
  input  logic [31:0] in_host_address_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_result_address_o,
  output logic [1:0]  out_status_o,
  output logic        out_is_free_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sapa_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // config writes complete in the access cycle, no wait states
  assign pready = 1'b1;

  // controller: sequences clear sweep, allocate scan and read-modify-write,
  // then parks the result in the output register
  sapa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd),
    .status_i    (dp_status)
  );

  // datapath: config registers, used bitmap memory, subnet math and results
  sapa_dp #(
    .POOL_ADDR_BITS (POOL_ADDR_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (ctrl_cmd),
    .status_o             (dp_status),
    .in_cmd_i             (in_cmd_i),
    .in_host_address_i    (in_host_address_i),
    .out_result_address_o (out_result_address_o),
    .out_status_o         (out_status_o),
    .out_is_free_o        (out_is_free_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata)
  );

endmodule

>>> design/sapa_checker.sv
// port-level checks for the subnet address pool allocator, bound to the top level
module sapa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_result_address_o,
  input logic [1:0]  out_status_o,
  input logic        out_is_free_o
);
  import sapa_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_result_address_o)
      && $stable(out_status_o) && $stable(out_is_free_o))
    else $error("result changed while stalled");

  // every result belongs to an accepted request, at most two in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> pend_q != 2'd0) and (pend_q != 2'd3))
    else $error("result without request or too many in flight");

  // block goes busy after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted while previous one in work");

  // result fields are consistent with each other
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_status_o != 2'd3
      && (!out_is_free_o || (out_status_o == ST_OK && out_result_address_o == 32'd0))
      && (out_result_address_o == 32'd0 || out_status_o == ST_OK))
    else $error("inconsistent result fields");

endmodule

bind subnet_address_pool_allocator_top sapa_checker u_sapa_checker (.*);
